// ===== rtl/hmlp_pkg.sv =====
// Shared types and constants for the linear-probe hash table.
package hmlp_pkg;

  // Command codes carried in the input word.
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // Finalizer constants of the 64-bit key hash.
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  typedef struct packed {
    logic        command;
    logic [63:0] key;
    logic [63:0] value;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [63:0] read_value;
  } out_word_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic        used;
    logic [63:0] key;
    logic [63:0] value;
  } slot_t;

endpackage

// ===== rtl/hmlp_hash.sv =====
// Multi-cycle 64-bit key finalizer built around one shared 32x32 multiplier.
module hmlp_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key,
  output logic        done,
  output logic [63:0] hash
);
  import hmlp_pkg::*;

  // Partial products of the truncated 64x64 multiply, one per cycle.
  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_HL = 2'd1;
  localparam logic [1:0] PART_LH = 2'd2;

  logic        busy_r, busy_nxt;
  logic        rnd_r, rnd_nxt;
  logic [1:0]  part_r, part_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        done_r, done_nxt;

  logic [63:0] mul_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] upper_sum;

  // Operand selection for the shared multiplier.
  assign mul_c = rnd_r ? MIX_C2 : MIX_C1;
  assign mul_a = (part_r == PART_HL) ? x_r[63:32] : x_r[31:0];
  assign mul_b = (part_r == PART_LH) ? mul_c[63:32] : mul_c[31:0];
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

  // A cross product only reaches the upper half of the truncated result.
  assign upper_sum = acc_r + {prod[31:0], 32'd0};

  // Sequencing of the two multiply rounds.
  always_comb begin
    busy_nxt = busy_r;
    rnd_nxt  = rnd_r;
    part_nxt = part_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      rnd_nxt  = 1'b0;
      part_nxt = PART_LL;
      x_nxt    = key ^ (key >> MIX_SHIFT);
    end else if (busy_r) begin
      case (part_r)
        PART_LL: begin
          acc_nxt  = prod;
          part_nxt = PART_HL;
        end
        PART_HL: begin
          acc_nxt  = upper_sum;
          part_nxt = PART_LH;
        end
        PART_LH: begin
          x_nxt    = upper_sum ^ (upper_sum >> MIX_SHIFT);
          part_nxt = PART_LL;
          rnd_nxt  = 1'b1;
          if (rnd_r) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: begin
          part_nxt = PART_LL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      part_r <= PART_LL;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rnd_r  <= rnd_nxt;
      part_r <= part_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign hash = x_r;

endmodule

// ===== rtl/hash_map_linear_probe.sv =====
// Open-addressing key-value table with linear probing over one slot memory.
//
// The input channel (in_valid, in_ready, in_word) takes one command word:
// a put stores value under key, a get looks key up. The result channel
// (out_valid, out_ready, out_word) returns exactly one word per command,
// in order: found plus read_value (zero unless a get hit).
// After reset the block sweeps the slot memory, clearing one used mark per
// cycle over every slot; in_ready stays low during that sweep.
// A command is hashed and then probes up to BUCKETS slots from its home
// slot: the key hash uses one 32x32 multiplier, and each probe is a memory
// read followed by a compare step on the slot memory. One command is in
// work at a time; the next word can be accepted in the cycle after the
// result is loaded. A finished word waits in the output register while the
// next command is accepted and hashed; a stalled receiver holds the block
// only when a second result is ready to be delivered.
module hash_map_linear_probe #(
  parameter int BUCKETS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hmlp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output hmlp_pkg::out_word_t out_word
);
  import hmlp_pkg::*;

  localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_PROBE = 6'b001000,
    S_CHECK = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  in_word_t    req_r, req_nxt;
  out_word_t   res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  slot_t       mem [BUCKETS];
  slot_t       rd_q;
  logic        mem_we;
  logic [IDX_W-1:0] mem_wa;
  slot_t       mem_wd;

  logic        in_take;
  logic        hash_done;
  logic [63:0] hash;
  logic        key_match;
  logic        last_probe;

  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;

  hmlp_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take),
    .key   (in_word.key),
    .done  (hash_done),
    .hash  (hash)
  );

  assign key_match  = rd_q.used && (rd_q.key == req_r.key);
  assign last_probe = (cnt_r == {IDX_W{1'b1}});

  // Control and probe sequencing.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    mem_we        = 1'b0;
    mem_wa        = addr_r;
    mem_wd        = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {IDX_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          req_nxt   = in_word;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          addr_nxt  = hash[IDX_W-1:0];
          cnt_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        res_nxt = '0;
        if (req_r.command == CMD_PUT) begin
          if (!rd_q.used || key_match) begin
            mem_we        = 1'b1;
            mem_wd.used   = 1'b1;
            mem_wd.key    = req_r.key;
            mem_wd.value  = req_r.value;
            res_nxt.found = 1'b1;
            state_nxt     = S_RESP;
          end else if (last_probe) begin
            state_nxt = S_RESP;
          end else begin
            addr_nxt  = addr_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_PROBE;
          end
        end else begin
          if (key_match) begin
            res_nxt.found      = 1'b1;
            res_nxt.read_value = rd_q.value;
            state_nxt          = S_RESP;
          end else if (!rd_q.used || last_probe) begin
            state_nxt = S_RESP;
          end else begin
            addr_nxt  = addr_r + 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_PROBE;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and probe registers need no reset.
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    cnt_r      <= cnt_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PROBE) begin
      rd_q <= mem[addr_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  // The clearing sweep ends only after the last slot has been cleared.
  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r == S_CLEAR) |-> ($past(clr_r) == {IDX_W{1'b1}}))
    else $error("clearing sweep ended early");

  // The hash unit finishes only for a command that is waiting on it.
  a_hash_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == S_HASH))
    else $error("hash finished outside the hash step");

  // A new result word appears only from the response step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result word loaded outside the response step");
`endif

endmodule

// ===== tb/hmlp_checker.sv =====
// Checker for the linear-probe hash table: predicts each result word and compares it.
module hmlp_checker #(
  parameter int BUCKETS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hmlp_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hmlp_pkg::out_word_t out_word,
  output int                  mismatches,
  output int                  outstanding
);
  import hmlp_pkg::*;

  // Finalizer constants of the key hash.
  localparam logic [63:0] HASH_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HASH_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int          HASH_SHIFT = 33;

  // Private copy of the table contents.
  logic        shadow_used [BUCKETS];
  logic [63:0] shadow_key  [BUCKETS];
  logic [63:0] shadow_val  [BUCKETS];

  // Result words still owed by the block, oldest first.
  out_word_t owed_results[$];
  int        mismatch_count = 0;

  assign mismatches = mismatch_count;

  // 64-bit finalizer: three xor-shifts with two wrapping multiplies between them.
  function automatic logic [63:0] finalize_key(input logic [63:0] k);
    logic [63:0] x;
    x = k ^ (k >> HASH_SHIFT);
    x = x * HASH_MUL_A;
    x = x ^ (x >> HASH_SHIFT);
    x = x * HASH_MUL_B;
    x = x ^ (x >> HASH_SHIFT);
    return x;
  endfunction

  // Walk the probe path from the home slot, updating the shadow table on a put.
  function automatic out_word_t probe_table(input in_word_t w);
    out_word_t   r;
    logic [63:0] home;
    int unsigned at;
    bit          done;
    r    = '0;
    home = finalize_key(w.key) & 64'(BUCKETS - 1);
    done = 1'b0;
    for (int n = 0; n < BUCKETS && !done; n++) begin
      at = (int'(home) + n) & (BUCKETS - 1);
      if (w.command == CMD_PUT) begin
        // A put claims the first free slot or the slot already holding the key.
        if (!shadow_used[at] || shadow_key[at] == w.key) begin
          shadow_used[at] = 1'b1;
          shadow_key[at]  = w.key;
          shadow_val[at]  = w.value;
          r.found         = 1'b1;
          done            = 1'b1;
        end
      end else begin
        // A get stops at the first free slot or at the key.
        if (!shadow_used[at]) begin
          done = 1'b1;
        end else if (shadow_key[at] == w.key) begin
          r.found      = 1'b1;
          r.read_value = shadow_val[at];
          done         = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Compare delivered words against the oldest prediction, then record new commands.
  always @(posedge clk) begin
    out_word_t want;
    bit        bad;
    if (!rst_n) begin
      for (int i = 0; i < BUCKETS; i++) begin
        shadow_used[i] = 1'b0;
      end
      owed_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result word: found=%0b read_value=%h",
                 out_word.found, out_word.read_value);
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          bad  = 1'b0;
          if (out_word.found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, out_word.found);
            bad = 1'b1;
          end
          if (out_word.read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h",
                   want.read_value, out_word.read_value);
            bad = 1'b1;
          end
          if (bad) begin
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        owed_results.push_back(probe_table(in_word));
      end
    end
    outstanding <= owed_results.size();
  end

endmodule

// ===== tb/tb_hash_map_linear_probe.sv =====
// Testbench top for the linear-probe hash table: stimulus, idling control and verdict.
module tb_hash_map_linear_probe;
  import hmlp_pkg::*;

  localparam int BUCKETS          = 256;
  localparam int KEY_POOL_SIZE    = 120;
  localparam int FRESH_PUT_MAX    = 80;
  localparam int RANDOM_PER_PHASE = 360;
  localparam int DRAIN_CYCLES     = 600;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  int        mismatches;
  int        outstanding;

  // Stimulus bookkeeping: which keys the table holds, and the idling levels.
  bit          stored_keys [logic [63:0]];
  logic [63:0] stored_list [$];
  logic [63:0] key_pool [KEY_POOL_SIZE];
  int          fresh_puts = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  hash_map_linear_probe #(.BUCKETS(BUCKETS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  hmlp_checker #(.BUCKETS(BUCKETS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver readiness, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Payloads mostly random, sometimes at the extremes.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(15))
      0:       return 64'h0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  // Alone, a side idles at a level of 76 percent; with both idling, 20 percent each.
  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct  = 76;
        recv_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct <= 76;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 20;
        recv_stall_pct <= 20;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct <= 0;
      end
    endcase
  endtask

  // Present one command word, with a random idle gap first, and wait for its acceptance.
  task automatic send_cmd(input logic cmd, input logic [63:0] key, input logic [63:0] value);
    in_word_t w;
    w.command = cmd;
    w.key     = key;
    w.value   = value;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    // A put of a new key lands unless the table is already full.
    if (cmd == CMD_PUT && !stored_keys.exists(key) && stored_keys.num() < BUCKETS) begin
      stored_keys[key] = 1'b1;
      stored_list.push_back(key);
    end
  endtask

  // Random traffic over a key pool, with fresh keys for misses and limited growth.
  task automatic run_random(input int count);
    logic        cmd;
    logic [63:0] key;
    for (int i = 0; i < count; i++) begin
      cmd = $urandom_range(1) ? CMD_GET : CMD_PUT;
      if ($urandom_range(99) < 80) begin
        key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      end else begin
        key = rand64();
        if (cmd == CMD_PUT) begin
          if (fresh_puts < FRESH_PUT_MAX) begin
            fresh_puts++;
          end else begin
            key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
          end
        end
      end
      send_cmd(cmd, key, pick_value());
    end
  endtask

  initial begin
    foreach (key_pool[i]) begin
      key_pool[i] = rand64();
    end
    set_idling(IDLE_NONE);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table miss, key and payload extremes, overwrite, misses.
    send_cmd(CMD_GET, 64'h0, 64'h0);
    send_cmd(CMD_PUT, 64'h0, '1);
    send_cmd(CMD_GET, 64'h0, 64'h0);
    send_cmd(CMD_PUT, '1, 64'h0);
    send_cmd(CMD_GET, '1, 64'h0);
    send_cmd(CMD_PUT, 64'h0, 64'h5555_5555_5555_5555);
    send_cmd(CMD_GET, 64'h0, '1);
    send_cmd(CMD_PUT, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
    send_cmd(CMD_PUT, 64'h1, 64'h1);
    send_cmd(CMD_GET, 64'h8000_0000_0000_0000, 64'h0);
    send_cmd(CMD_GET, 64'h1, 64'h0);
    send_cmd(CMD_GET, 64'h2, 64'h0);
    send_cmd(CMD_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0001);
    send_cmd(CMD_GET, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0);
    send_cmd(CMD_GET, 64'h5555_5555_5555_5555, '1);

    // Random traffic under each idling pattern.
    set_idling(IDLE_NONE);
    run_random(RANDOM_PER_PHASE);
    set_idling(IDLE_SENDER);
    run_random(RANDOM_PER_PHASE);
    set_idling(IDLE_RECEIVER);
    run_random(RANDOM_PER_PHASE);
    set_idling(IDLE_BOTH);
    run_random(RANDOM_PER_PHASE);

    // Fill the table, then drop puts, walk full-length misses and overwrite in place.
    while (stored_keys.num() < BUCKETS) begin
      send_cmd(CMD_PUT, rand64(), pick_value());
    end
    repeat (8) begin
      send_cmd(CMD_PUT, rand64(), pick_value());
      send_cmd(CMD_GET, rand64(), pick_value());
      send_cmd(CMD_GET, stored_list[$urandom_range(stored_list.size() - 1)], pick_value());
    end
    repeat (4) begin
      send_cmd(CMD_PUT, stored_list[$urandom_range(stored_list.size() - 1)], pick_value());
    end
    send_cmd(CMD_GET, stored_list[0], 64'h0);
    in_valid <= 1'b0;

    // Drain, then give a stray word time to show up.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
